/* src/satenc_pkg.sv */
package satenc_pkg;

	localparam int MAX_SIDE     = 1024;
	localparam int MAX_CHANNELS = 1024;
	localparam int MAX_IMAGES   = 64;
	localparam int VALUE_BITS   = 32;

	// Result queue depth and pointer width
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	localparam logic [19:0] RUN_MAX = 20'hFFFFF;
	localparam logic [20:0] NZ_MAX  = 21'h1FFFFF;

	// Register indexes of the write port
	localparam logic [2:0] REG_NUM_IMAGES   = 3'd0;
	localparam logic [2:0] REG_NUM_CHANNELS = 3'd1;
	localparam logic [2:0] REG_ROW_START    = 3'd2;
	localparam logic [2:0] REG_ROW_COUNT    = 3'd3;
	localparam logic [2:0] REG_COL_START    = 3'd4;
	localparam logic [2:0] REG_COL_COUNT    = 3'd5;

	// Result kinds
	localparam logic KIND_ENTRY   = 1'b0;
	localparam logic KIND_TRAILER = 1'b1;

	typedef struct packed {
		logic [6:0]  num_images;
		logic [10:0] num_channels;
		logic [9:0]  row_start;
		logic [10:0] row_count;
		logic [9:0]  col_start;
		logic [10:0] col_count;
	} cfg_t;

	typedef struct packed {
		logic                  kind;
		logic [VALUE_BITS-1:0] nonzero_value;
		logic [19:0]           zero_run;
		logic [5:0]            image_index;
		logic [9:0]            channel_index;
		logic [9:0]            row_index;
		logic [9:0]            col_index;
		logic [20:0]           plane_nonzeros;
		logic                  plane_end;
	} result_t;

	// Write strobes into the result queue; a lone result always takes the first slot
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	// Zero count acts as one, oversized count acts as the cap
	function automatic logic [10:0] eff_side(input logic [10:0] v);
		logic [10:0] r;
		if (v == 11'd0) begin
			r = 11'd1;
		end else if (v > 11'(MAX_SIDE)) begin
			r = 11'(MAX_SIDE);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [10:0] eff_chan(input logic [10:0] v);
		logic [10:0] r;
		if (v == 11'd0) begin
			r = 11'd1;
		end else if (v > 11'(MAX_CHANNELS)) begin
			r = 11'(MAX_CHANNELS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [6:0] eff_img(input logic [6:0] v);
		logic [6:0] r;
		if (v == 7'd0) begin
			r = 7'd1;
		end else if (v > 7'(MAX_IMAGES)) begin
			r = 7'(MAX_IMAGES);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* src/satenc_walk.sv */
module satenc_walk
	import satenc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  advance,
	input  logic [VALUE_BITS-1:0] element,
	output push_t                 push,
	output result_t               res_first,
	output result_t               res_second
);

	logic [19:0] run_q;
	logic [20:0] nz_q;
	logic [5:0]  image_q;
	logic [9:0]  chan_q;
	logic [9:0]  row_q;
	logic [9:0]  col_q;

	logic        is_nz;
	logic [20:0] nz_inc;
	logic        col_wrap;
	logic        row_wrap;
	logic        chan_wrap;
	logic        img_wrap;
	logic        plane_done;
	result_t     entry;
	result_t     trailer;

	// Zero test ignores the sign bit
	assign is_nz = |element[VALUE_BITS-2:0];

	assign nz_inc = (is_nz && nz_q != NZ_MAX) ? nz_q + 21'd1 : nz_q;

	assign col_wrap   = ({1'b0, col_q} + 11'd1) >= eff_side(cfg.col_count);
	assign row_wrap   = ({1'b0, row_q} + 11'd1) >= eff_side(cfg.row_count);
	assign chan_wrap  = ({1'b0, chan_q} + 11'd1) >= eff_chan(cfg.num_channels);
	assign img_wrap   = ({1'b0, image_q} + 7'd1) >= eff_img(cfg.num_images);
	assign plane_done = col_wrap && row_wrap;

	// Build entry and trailer from the current position
	always_comb begin
		entry.kind           = KIND_ENTRY;
		entry.nonzero_value  = element;
		entry.zero_run       = run_q;
		entry.image_index    = image_q;
		entry.channel_index  = chan_q;
		entry.row_index      = cfg.row_start + row_q;
		entry.col_index      = cfg.col_start + col_q;
		entry.plane_nonzeros = '0;
		entry.plane_end      = 1'b0;

		trailer.kind           = KIND_TRAILER;
		trailer.nonzero_value  = '0;
		trailer.zero_run       = '0;
		trailer.image_index    = image_q;
		trailer.channel_index  = chan_q;
		trailer.row_index      = '0;
		trailer.col_index      = '0;
		trailer.plane_nonzeros = nz_inc;
		trailer.plane_end      = 1'b1;
	end

	// Entry goes first when both are produced
	assign res_first   = is_nz ? entry : trailer;
	assign res_second  = trailer;
	assign push.first  = advance && (is_nz || plane_done);
	assign push.second = advance && is_nz && plane_done;

	// Advance counters and position on each processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= '0;
			nz_q    <= '0;
			image_q <= '0;
			chan_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else if (advance) begin
			if (plane_done || is_nz) begin
				run_q <= '0;
			end else if (run_q != RUN_MAX) begin
				run_q <= run_q + 20'd1;
			end
			nz_q <= plane_done ? 21'd0 : nz_inc;

			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? 10'd0 : row_q + 10'd1;
			end else begin
				col_q <= col_q + 10'd1;
			end

			if (plane_done) begin
				if (chan_wrap) begin
					chan_q  <= '0;
					image_q <= img_wrap ? 6'd0 : image_q + 6'd1;
				end else begin
					chan_q <= chan_q + 10'd1;
				end
			end
		end
	end

	// A finished plane clears its counters and returns to the tile origin
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && plane_done) |=> (run_q == 20'd0 && nz_q == 21'd0
			&& row_q == 10'd0 && col_q == 10'd0))
		else $error("plane close did not clear counters");

	// A nonzero restarts the zero run
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_nz) |=> (run_q == 20'd0))
		else $error("zero run not restarted after nonzero");

	// Two results only when the plane ends on a nonzero
	assert property (@(posedge clk) disable iff (!arst_n)
		push.second |-> (push.first && res_first.kind == KIND_ENTRY
			&& res_second.kind == KIND_TRAILER))
		else $error("result pair out of order");

endmodule

/* src/satenc_outq.sv */
module satenc_outq
	import satenc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  result_t wr_first,
	input  result_t wr_second,
	output logic    room2,
	input  logic    pop,
	output logic    rd_valid,
	output result_t rd_data
);

	result_t               mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_ptr_q;
	logic [OUTQ_PTR_W-1:0] rd_ptr_q;
	logic [OUTQ_CNT_W-1:0] count_q;
	logic [OUTQ_PTR_W-1:0] wr_ptr_nx;
	logic [OUTQ_CNT_W-1:0] n_push;
	logic                  do_pop;

	assign wr_ptr_nx = wr_ptr_q + OUTQ_PTR_W'(1);
	assign n_push    = OUTQ_CNT_W'(push.first) + OUTQ_CNT_W'(push.second);
	assign do_pop    = pop && rd_valid;

	assign room2    = count_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];

	// Store up to two results per cycle
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_ptr_q] <= wr_first;
		end
		if (push.second) begin
			mem_q[wr_ptr_nx] <= wr_second;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUTQ_PTR_W'(n_push);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(1);
			end
			count_q <= count_q + n_push - OUTQ_CNT_W'(do_pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OUTQ_CNT_W'(OUTQ_DEPTH))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		push.first |-> room2)
		else $error("push into queue without room");

	assert property (@(posedge clk) disable iff (!arst_n)
		push.second |-> push.first)
		else $error("second slot written without first");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!push.first && !do_pop) |=> (count_q == $past(count_q)))
		else $error("queue level changed while idle");

endmodule

/* src/sparse_activation_tile_encoder_core.sv */
// Zero-run sparse encoder for one activation tile. Elements enter one per cycle in
// image, channel, row, column order; each nonzero yields an entry (value, zeros
// skipped, absolute coordinates), each finished plane a trailer with its nonzero
// count, and trailing zeros yield nothing. An element is taken every cycle while
// the four-deep result queue holds two results or fewer; results leave at one per
// cycle while out_ready is high, so with a ready output only a plane that ends on a
// nonzero (two results from one element) can slow the input, and then to the output
// rate. A request is held in an input register, then its results enter the queue.
// Configuration writes take effect at once and must be made while no request is in flight.
module sparse_activation_tile_encoder_core
	import satenc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [10:0]           cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] element,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  kind,
	output logic [VALUE_BITS-1:0] nonzero_value,
	output logic [19:0]           zero_run,
	output logic [5:0]            image_index,
	output logic [9:0]            channel_index,
	output logic [9:0]            row_index,
	output logic [9:0]            col_index,
	output logic [20:0]           plane_nonzeros,
	output logic                  plane_end
);

	cfg_t                  cfg_q;
	logic [VALUE_BITS-1:0] element_s1;
	logic                  valid_s1;
	logic                  advance;
	logic                  room2;
	push_t                 push;
	result_t               res_first;
	result_t               res_second;
	result_t               head;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_images   <= 7'd1;
			cfg_q.num_channels <= 11'd1;
			cfg_q.row_start    <= 10'd0;
			cfg_q.row_count    <= 11'd1;
			cfg_q.col_start    <= 10'd0;
			cfg_q.col_count    <= 11'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_IMAGES:   cfg_q.num_images   <= cfg_data[6:0];
				REG_NUM_CHANNELS: cfg_q.num_channels <= cfg_data;
				REG_ROW_START:    cfg_q.row_start    <= cfg_data[9:0];
				REG_ROW_COUNT:    cfg_q.row_count    <= cfg_data;
				REG_COL_START:    cfg_q.col_start    <= cfg_data[9:0];
				REG_COL_COUNT:    cfg_q.col_count    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Process the held request once the queue has room for two results
	assign advance  = valid_s1 && room2;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			element_s1 <= element;
		end
	end

	satenc_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.advance    (advance),
		.element    (element_s1),
		.push       (push),
		.res_first  (res_first),
		.res_second (res_second)
	);

	satenc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_first  (res_first),
		.wr_second (res_second),
		.room2     (room2),
		.pop       (out_ready),
		.rd_valid  (out_valid),
		.rd_data   (head)
	);

	// Drive result ports from the queue head
	assign kind           = head.kind;
	assign nonzero_value  = head.nonzero_value;
	assign zero_run       = head.zero_run;
	assign image_index    = head.image_index;
	assign channel_index  = head.channel_index;
	assign row_index      = head.row_index;
	assign col_index      = head.col_index;
	assign plane_nonzeros = head.plane_nonzeros;
	assign plane_end      = head.plane_end;

	// A held request is never dropped: if not processed it stays held
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(element_s1)))
		else $error("stalled request lost");

	// Input stalls only when the result queue lacks room for two results
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && !room2))
		else $error("input stalled without cause");

	// Results only appear from processed requests
	assert property (@(posedge clk) disable iff (!arst_n)
		(push.first || push.second) |-> advance)
		else $error("result pushed without request");

endmodule

/* bench/sparse_activation_tile_encoder_core_tb.sv */
`timescale 1ns / 100ps

module sparse_activation_tile_encoder_core_tb
	import satenc_pkg::*;
;

	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_NS     = 5_000_000;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef enum logic {
		ROW_CFG,
		ROW_ELEM
	} row_op_t;

	// How a directed element row is checked
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_TRAILER_ONLY,
		CHK_ENTRY_TRAILER
	} row_chk_t;

	typedef struct packed {
		row_op_t     op;
		logic [2:0]  idx;
		logic [10:0] data;
		logic [31:0] elem;
		row_chk_t    chk;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [2:0]            cfg_index;
	logic [10:0]           cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [VALUE_BITS-1:0] element;
	logic                  out_valid;
	logic                  out_ready;
	logic                  kind;
	logic [VALUE_BITS-1:0] nonzero_value;
	logic [19:0]           zero_run;
	logic [5:0]            image_index;
	logic [9:0]            channel_index;
	logic [9:0]            row_index;
	logic [9:0]            col_index;
	logic [20:0]           plane_nonzeros;
	logic                  plane_end;

	// Encoder shadow: configuration and tile position
	logic [6:0]  tile_images    = 7'd1;
	logic [10:0] tile_channels  = 11'd1;
	logic [9:0]  tile_row_start = 10'd0;
	logic [10:0] tile_row_count = 11'd1;
	logic [9:0]  tile_col_start = 10'd0;
	logic [10:0] tile_col_count = 11'd1;
	logic [19:0] zeros_seen     = '0;
	logic [20:0] plane_count    = '0;
	logic [5:0]  at_image       = '0;
	logic [9:0]  at_channel     = '0;
	logic [9:0]  at_row         = '0;
	logic [9:0]  at_col         = '0;

	result_t pending_results[$];
	result_t want;
	int      fail_count     = 0;
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;

	sparse_activation_tile_encoder_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.element       (element),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.nonzero_value (nonzero_value),
		.zero_run      (zero_run),
		.image_index   (image_index),
		.channel_index (channel_index),
		.row_index     (row_index),
		.col_index     (col_index),
		.plane_nonzeros(plane_nonzeros),
		.plane_end     (plane_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	// Zero acts as one, anything above the cap acts as the cap
	function automatic int clamp_count(input int v, input int cap);
		if (v == 0) begin
			return 1;
		end
		return (v > cap) ? cap : v;
	endfunction

	// Append one expected result at the tail
	function automatic void expect_result(input result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Encode one element; return how many results it yields
	function automatic int encode_step(input logic [31:0] e, output result_t res0,
			output result_t res1);
		result_t r;
		int      n;
		n = 0;
		res0 = '0;
		res1 = '0;
		if (e[30:0] != 31'd0) begin
			r = '0;
			r.kind = KIND_ENTRY;
			r.nonzero_value = e;
			r.zero_run = zeros_seen;
			r.image_index = at_image;
			r.channel_index = at_channel;
			r.row_index = tile_row_start + at_row;
			r.col_index = tile_col_start + at_col;
			res0 = r;
			n = 1;
			zeros_seen = '0;
			if (plane_count != NZ_MAX) begin
				plane_count = plane_count + 1'b1;
			end
		end else if (zeros_seen != RUN_MAX) begin
			zeros_seen = zeros_seen + 1'b1;
		end

		// advance column, row, plane, batch
		if (int'(at_col) + 1 >= clamp_count(int'(tile_col_count), MAX_SIDE)) begin
			at_col = '0;
			if (int'(at_row) + 1 >= clamp_count(int'(tile_row_count), MAX_SIDE)) begin
				at_row = '0;
				r = '0;
				r.kind = KIND_TRAILER;
				r.image_index = at_image;
				r.channel_index = at_channel;
				r.plane_nonzeros = plane_count;
				r.plane_end = 1'b1;
				if (n == 0) begin
					res0 = r;
				end else begin
					res1 = r;
				end
				n++;
				zeros_seen = '0;
				plane_count = '0;
				if (int'(at_channel) + 1 >=
						clamp_count(int'(tile_channels), MAX_CHANNELS)) begin
					at_channel = '0;
					if (int'(at_image) + 1 >= clamp_count(int'(tile_images), MAX_IMAGES)) begin
						at_image = '0;
					end else begin
						at_image = at_image + 1'b1;
					end
				end else begin
					at_channel = at_channel + 1'b1;
				end
			end else begin
				at_row = at_row + 1'b1;
			end
		end else begin
			at_col = at_col + 1'b1;
		end
		return n;
	endfunction

	function automatic logic [31:0] gen_element(input int zero_pct);
		logic [31:0] v;
		v = $urandom;
		// keep the random sign so both zeros show up
		if ($urandom_range(99) < zero_pct) begin
			v[30:0] = '0;
		end
		return v;
	endfunction

	function automatic int pick_count(input int over, input int cap);
		case ($urandom_range(9))
			0: return 0;
			1: return over;
			2: return cap;
			default: return $urandom_range(4, 1);
		endcase
	endfunction

	function automatic int pick_start();
		case ($urandom_range(3))
			0: return 0;
			1: return 1023;
			default: return $urandom_range(1023);
		endcase
	endfunction

	function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [10:0] data);
		return '{ROW_CFG, idx, data, 32'h0, CHK_MODEL};
	endfunction

	function automatic stim_row_t elem_row(input logic [31:0] e, input row_chk_t chk);
		return '{ROW_ELEM, 3'd0, 11'd0, e, chk};
	endfunction

	task automatic set_mode(input idle_mode_t m);
		send_idle_pct = (m == IDLE_SEND) ? 84 : (m == IDLE_BOTH) ? 26 : 0;
		recv_stall_pct = (m == IDLE_RECV) ? 84 : (m == IDLE_BOTH) ? 26 : 0;
	endtask

	// Write one register; entered and left at a falling edge
	task automatic set_register(input logic [2:0] idx, input logic [10:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_NUM_IMAGES:   tile_images = data[6:0];
			REG_NUM_CHANNELS: tile_channels = data;
			REG_ROW_START:    tile_row_start = data[9:0];
			REG_ROW_COUNT:    tile_row_count = data;
			REG_COL_START:    tile_col_start = data[9:0];
			REG_COL_COUNT:    tile_col_count = data;
			default: ;
		endcase
	endtask

	// Offer one request and hold it until taken; returns at a falling edge, valid still high
	task automatic send_element(input logic [31:0] e, input bit from_model);
		result_t r0;
		result_t r1;
		int      n;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		element <= e;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		n = encode_step(e, r0, r1);
		if (from_model) begin
			if (n > 0) begin
				expect_result(r0);
			end
			if (n > 1) begin
				expect_result(r1);
			end
		end
		@(negedge clk);
	endtask

	// Drop valid and let the block go quiet
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
			fail_count++;
		end
	endtask

	// Stall the result side at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, actual kind %h value %h plane_nz %h",
					$time, kind, nonzero_value, plane_nonzeros);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("nonzero_value", want.nonzero_value, nonzero_value);
				check_field("zero_run", 32'(want.zero_run), 32'(zero_run));
				check_field("image_index", 32'(want.image_index), 32'(image_index));
				check_field("channel_index", 32'(want.channel_index), 32'(channel_index));
				check_field("row_index", 32'(want.row_index), 32'(row_index));
				check_field("col_index", 32'(want.col_index), 32'(col_index));
				check_field("plane_nonzeros", 32'(want.plane_nonzeros),
					32'(plane_nonzeros));
				check_field("plane_end", 32'(want.plane_end), 32'(plane_end));
			end
		end
	end

	initial begin : stimulus
		stim_row_t   plan[$];
		stim_row_t   row;
		result_t     typed_res;
		int          n_items;
		int          zero_pct;
		int          imgs;
		int          chans;
		int          rows;
		int          cols;
		int          rstart;
		int          cstart;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		element = '0;
		set_mode(IDLE_NONE);

		// Reset config makes every element a plane of its own
		plan.insert(plan.size(), elem_row(32'h0000_0000, CHK_TRAILER_ONLY));
		plan.insert(plan.size(), elem_row(32'h8000_0000, CHK_TRAILER_ONLY));
		plan.insert(plan.size(), elem_row(32'h0000_0001, CHK_ENTRY_TRAILER));
		plan.insert(plan.size(), elem_row(32'hFFFF_FFFF, CHK_ENTRY_TRAILER));
		plan.insert(plan.size(), elem_row(32'h7FFF_FFFF, CHK_ENTRY_TRAILER));
		plan.insert(plan.size(), elem_row(32'h8000_0001, CHK_ENTRY_TRAILER));
		// 2x2 tile hanging past the row edge, two channels, zero image count
		plan.insert(plan.size(), cfg_row(REG_NUM_IMAGES, 11'd0));
		plan.insert(plan.size(), cfg_row(REG_NUM_CHANNELS, 11'd2));
		plan.insert(plan.size(), cfg_row(REG_ROW_START, 11'd1023));
		plan.insert(plan.size(), cfg_row(REG_ROW_COUNT, 11'd2));
		plan.insert(plan.size(), cfg_row(REG_COL_START, 11'd1022));
		plan.insert(plan.size(), cfg_row(REG_COL_COUNT, 11'd2));
		plan.insert(plan.size(), elem_row(32'h0000_0000, CHK_MODEL));
		plan.insert(plan.size(), elem_row(32'h0000_0005, CHK_MODEL));
		plan.insert(plan.size(), elem_row(32'h0000_0000, CHK_MODEL));
		plan.insert(plan.size(), elem_row(32'h8000_0000, CHK_MODEL));
		plan.insert(plan.size(), elem_row(32'h8000_0000, CHK_MODEL));
		plan.insert(plan.size(), elem_row(32'h1234_5678, CHK_MODEL));
		plan.insert(plan.size(), elem_row(32'hC000_0000, CHK_MODEL));
		plan.insert(plan.size(), elem_row(32'h0000_0000, CHK_MODEL));
		// widen the row, then shrink it under the current column
		plan.insert(plan.size(), cfg_row(REG_COL_COUNT, 11'd4));
		plan.insert(plan.size(), elem_row(32'h0000_0001, CHK_MODEL));
		plan.insert(plan.size(), elem_row(32'h0000_0000, CHK_MODEL));
		plan.insert(plan.size(), cfg_row(REG_COL_COUNT, 11'd1));
		plan.insert(plan.size(), elem_row(32'h4000_0000, CHK_MODEL));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		foreach (plan[i]) begin
			row = plan[i];
			if (row.op == ROW_CFG) begin
				drain_block();
				set_register(row.idx, row.data);
			end else begin
				if (row.chk == CHK_ENTRY_TRAILER) begin
					typed_res = '0;
					typed_res.kind = KIND_ENTRY;
					typed_res.nonzero_value = row.elem;
					expect_result(typed_res);
				end
				if (row.chk != CHK_MODEL) begin
					typed_res = '0;
					typed_res.kind = KIND_TRAILER;
					typed_res.plane_nonzeros = (row.chk == CHK_ENTRY_TRAILER) ? 21'd1 : 21'd0;
					typed_res.plane_end = 1'b1;
					expect_result(typed_res);
				end
				send_element(row.elem, row.chk == CHK_MODEL);
			end
		end

		// Random phases, each with its own tile and idling
		for (int p = 0; p < 10; p++) begin
			drain_block();
			set_mode(idle_mode_t'(p % 4));
			if (p == 1) begin
				// oversized image count with one-element planes: batch wraps at the cap
				imgs = 127;
				chans = 0;
				rows = 0;
				cols = 0;
				rstart = 1023;
				cstart = 1023;
				n_items = 150;
				zero_pct = 40;
			end else if (p == 4) begin
				// oversized row width: the row closes at the side cap
				imgs = 1;
				chans = 1;
				rows = 2;
				cols = 2047;
				rstart = 1023;
				cstart = pick_start();
				n_items = 1040;
				zero_pct = 75;
			end else begin
				imgs = pick_count(127, MAX_IMAGES);
				chans = pick_count(2047, MAX_CHANNELS);
				rows = pick_count(2047, MAX_SIDE);
				cols = pick_count(2047, MAX_SIDE);
				rstart = pick_start();
				cstart = pick_start();
				n_items = 70;
				zero_pct = 50;
			end
			// junk in the unused upper bits of the narrow registers
			set_register(REG_NUM_IMAGES, {4'($urandom), 7'(imgs)});
			set_register(REG_NUM_CHANNELS, 11'(chans));
			set_register(REG_ROW_START, {1'($urandom), 10'(rstart)});
			set_register(REG_ROW_COUNT, 11'(rows));
			set_register(REG_COL_START, {1'($urandom), 10'(cstart)});
			set_register(REG_COL_COUNT, 11'(cols));
			repeat (n_items) send_element(gen_element(zero_pct), 1'b1);
		end

		drain_block();
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/satenc_pkg.sv
src/satenc_walk.sv
src/satenc_outq.sv
src/sparse_activation_tile_encoder_core.sv
bench/sparse_activation_tile_encoder_core_tb.sv
